/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DPBE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpbe assertion failed");

// Next-cycle implication, disabled during reset.
`define DPBE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpbe assertion failed");

`endif

/* rtl/dpbe_pkg.sv */
// Types, codes and encoding tables for the data-processing/branch encoder.
// No dependencies.
package dpbe_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned INDEX_W = 24;
    localparam int unsigned PADDR_W = 2;

    localparam logic [PADDR_W-1:0] ADDR_PROGRAM_WORDS = 2'd0;
    localparam logic [INDEX_W-1:0] PROGRAM_WORDS_RESET = 24'hFFFFFF;

    localparam logic [WORD_W-1:0] BRANCH_BASE = 32'h0A00_0000;
    localparam logic [3:0]        REG_MAX     = 4'd12;

    typedef enum logic [3:0] {
        OP_AND    = 4'd0,
        OP_EOR    = 4'd1,
        OP_SUB    = 4'd2,
        OP_RSB    = 4'd3,
        OP_ADD    = 4'd4,
        OP_ORR    = 4'd5,
        OP_MOV    = 4'd6,
        OP_TST    = 4'd7,
        OP_TEQ    = 4'd8,
        OP_CMP    = 4'd9,
        OP_BRANCH = 4'd10
    } op_e;

    typedef enum logic [2:0] {
        CS_EQ = 3'd0,
        CS_NE = 3'd1,
        CS_GE = 3'd2,
        CS_LT = 3'd3,
        CS_GT = 3'd4,
        CS_LE = 3'd5,
        CS_AL = 3'd6
    } cond_sel_e;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_REG    = 2'd1,
        ERR_IMM    = 2'd2,
        ERR_BRANCH = 2'd3
    } err_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_FIN
    } state_e;

    typedef struct packed {
        logic [3:0]         op;
        logic [2:0]         cond_sel;
        logic [3:0]         dest_reg;
        logic [3:0]         first_reg;
        logic               imm_flag;
        logic [WORD_W-1:0]  operand_value;
        logic [3:0]         second_reg;
        logic [1:0]         shift_kind;
        logic               shift_by_reg;
        logic [4:0]         shift_amount;
        logic [3:0]         shift_reg;
        logic [INDEX_W-1:0] instr_index;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] instr_word;
        logic [1:0]        error_code;
    } out_item_t;

    // sequencer -> normalizer
    typedef struct packed {
        logic load;
        logic step;
    } norm_ctrl_t;

    // normalizer -> sequencer
    typedef struct packed {
        logic              done;
        logic [3:0]        pairs;
        logic [WORD_W-1:0] value;
    } norm_stat_t;

    function automatic logic [3:0] cond_code(input logic [2:0] sel);
        logic [3:0] code;
        case (sel)
            CS_EQ:   code = 4'h0;
            CS_NE:   code = 4'h1;
            CS_GE:   code = 4'hA;
            CS_LT:   code = 4'hB;
            CS_GT:   code = 4'hC;
            CS_LE:   code = 4'hD;
            default: code = 4'hE;   // al, and the unused code
        endcase
        return code;
    endfunction

    function automatic logic [3:0] opcode_bits(input logic [3:0] op);
        logic [3:0] code;
        case (op)
            OP_AND:  code = 4'h0;
            OP_EOR:  code = 4'h1;
            OP_SUB:  code = 4'h2;
            OP_RSB:  code = 4'h3;
            OP_ADD:  code = 4'h4;
            OP_ORR:  code = 4'hC;
            OP_MOV:  code = 4'hD;
            OP_TST:  code = 4'h8;
            OP_TEQ:  code = 4'h9;
            OP_CMP:  code = 4'hA;
            default: code = 4'h0;
        endcase
        return code;
    endfunction

endpackage

/* rtl/dpbe_norm.sv */
// Immediate normalizer: strips one pair of trailing zero bits per step.
// Depends on dpbe_pkg.
module dpbe_norm (
    input  logic                clk,
    input  dpbe_pkg::norm_ctrl_t ctrl,
    input  logic [31:0]         load_value,
    output dpbe_pkg::norm_stat_t stat
);
    import dpbe_pkg::*;

    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;
    logic [3:0]        pairs_reg;
    logic [3:0]        pairs_next;
    logic              done;

    // stop once the low pair is nonzero, or nothing is left
    assign done = (value_reg[1:0] != 2'b00) || (value_reg == '0);

    always_comb
    begin
        value_next = value_reg;
        pairs_next = pairs_reg;
        if (ctrl.load)
        begin
            value_next = load_value;
            pairs_next = 4'd0;
        end
        else if (ctrl.step && !done)
        begin
            value_next = value_reg >> 2;
            pairs_next = pairs_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pairs_reg <= pairs_next;
    end

    assign stat.done  = done;
    assign stat.pairs = pairs_reg;
    assign stat.value = value_reg;

endmodule

/* rtl/data_processing_branch_encoder.sv */
// Top level of the data-processing/branch instruction encoder.
// Depends on dpbe_pkg and dpbe_norm.
//
// Encodes one tokenized instruction per item into a 32-bit word plus error
// code. The item is held while the normalizer strips trailing zero pairs
// of the operand, one pair per cycle; in_ready is low meanwhile. An item
// goes from ST_NORM, where k zero pairs (0 to 15) are stripped, to ST_FIN
// and back to ST_IDLE before the next item is accepted. The result sits
// in an output register, so a new item is taken while it waits; that
// next item then holds in its last cycle until the result is taken.
// program_words is written through the APB port at address 0.
module data_processing_branch_encoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dpbe_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dpbe_pkg::out_item_t   out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import dpbe_pkg::*;

    state_e     state_reg;
    state_e     state_next;
    in_item_t   item_reg;
    in_item_t   item_next;
    out_item_t  out_reg;
    out_item_t  out_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [INDEX_W-1:0] pw_reg;
    logic [INDEX_W-1:0] pw_next;

    norm_ctrl_t norm_ctrl;
    norm_stat_t norm_stat;

    out_item_t  result;

    dpbe_norm u_norm (
        .clk        (clk),
        .ctrl       (norm_ctrl),
        .load_value (in_item.operand_value),
        .stat       (norm_stat)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PROGRAM_WORDS) ? {8'd0, pw_reg} : 32'd0;

    always_comb
    begin
        pw_next = pw_reg;
        if (psel && penable && pwrite && pready && (paddr == ADDR_PROGRAM_WORDS))
            pw_next = pwdata[INDEX_W-1:0];
    end

    // result of the held item
    always_comb
    begin
        logic [3:0]         cond;
        logic [3:0]         rd;
        logic [3:0]         rn;
        logic               set_s;
        logic [11:0]        operand2;
        logic [7:0]         shift;
        logic [3:0]         rot;
        logic [INDEX_W-1:0] offset;
        logic               past_end;

        cond     = cond_code(item_reg.cond_sel);
        rd       = item_reg.dest_reg;
        rn       = item_reg.first_reg;
        set_s    = 1'b0;
        operand2 = 12'd0;
        result.instr_word = '0;
        result.error_code = ERR_OK;

        past_end = (item_reg.operand_value[31:26] != 6'd0)
                || (item_reg.operand_value[25:0] >= {pw_reg, 2'b00});
        offset   = item_reg.operand_value[25:2] - 24'd2 - item_reg.instr_index;

        shift = item_reg.shift_by_reg
              ? {item_reg.shift_reg, 1'b0, item_reg.shift_kind, 1'b1}
              : {item_reg.shift_amount, item_reg.shift_kind, 1'b0};
        rot   = 4'd0 - norm_stat.pairs;   // 16 - pairs, zero when none stripped

        if (item_reg.op == OP_BRANCH)
        begin
            if ((item_reg.operand_value[1:0] != 2'b00) || past_end)
                result.error_code = ERR_BRANCH;
            else
                result.instr_word = BRANCH_BASE | {cond, 28'd0} | {8'd0, offset};
        end
        else if (item_reg.op < OP_BRANCH)
        begin
            if (item_reg.op == OP_MOV)
                rn = 4'd0;
            else if (item_reg.op inside {OP_TST, OP_TEQ, OP_CMP})
            begin
                rd    = 4'd0;
                set_s = 1'b1;
            end

            if ((rd > REG_MAX) || (rn > REG_MAX))
                result.error_code = ERR_REG;
            else if (item_reg.imm_flag)
            begin
                if (norm_stat.value[31:8] != 24'd0)
                    result.error_code = ERR_IMM;
                operand2 = {rot, norm_stat.value[7:0]};
            end
            else
            begin
                if ((item_reg.second_reg > REG_MAX)
                    || (item_reg.shift_by_reg && (item_reg.shift_reg > REG_MAX)))
                    result.error_code = ERR_REG;
                operand2 = {shift, item_reg.second_reg};
            end

            if (result.error_code == ERR_OK)
                result.instr_word = {cond, 2'b00, item_reg.imm_flag,
                                     opcode_bits(item_reg.op), set_s,
                                     rn, rd, operand2};
        end
    end

    // sequencer
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        norm_ctrl.load = 1'b0;
        norm_ctrl.step = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next      = in_item;
                    norm_ctrl.load = 1'b1;
                    state_next     = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (norm_stat.done || !item_reg.imm_flag)
                    state_next = ST_FIN;
                else
                    norm_ctrl.step = 1'b1;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = result;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pw_reg        <= PROGRAM_WORDS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pw_reg        <= pw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* rtl/dpbe_checker.sv */
// Port-level checks for the data-processing/branch encoder, bound to its top.
// Depends on dpbe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dpbe_assertions (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input dpbe_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_ready,
    input dpbe_pkg::out_item_t out_item,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [1:0]          paddr,
    input logic [31:0]         pwdata,
    input logic [31:0]         prdata,
    input logic                pready
);
    import dpbe_pkg::*;

    logic in_fire;
    logic cfg_fire;
    logic cfg_known;
    logic out_err;
    logic out_stall;
    logic rd_other;

    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = psel && penable && pwrite && pready && (paddr == ADDR_PROGRAM_WORDS);
    assign cfg_known = cfg_fire && !$isunknown(pwdata);
    assign out_err   = out_valid && (out_item.error_code != ERR_OK);
    assign out_stall = out_valid && !out_ready;
    assign rd_other  = (paddr != ADDR_PROGRAM_WORDS);

    // one item at a time: busy right after taking one
    `DPBE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)

    // any error forces a zero word
    `DPBE_ASSERT_SAME(a_err_zero_word, clk, rst_n, out_err, out_item.instr_word == 32'd0)

    // a stalled result holds
    `DPBE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_item))

    // register readback follows the last write
    `DPBE_ASSERT_NEXT(a_cfg_readback, clk, rst_n, cfg_known, rd_other || (prdata[23:0] == $past(pwdata[23:0])))

endmodule

bind data_processing_branch_encoder dpbe_assertions u_dpbe_assertions (.*);
